// ----- rtl/core/pft_pkg.sv -----
// ----------------------------------------------------------------------------
// pft_pkg
// Shared types and constants for the polygon fan triangulator.
// ----------------------------------------------------------------------------
package pft_pkg;

  localparam int INDEX_BITS       = 24;
  localparam int POINT_COUNT_BITS = 25;
  localparam int RAW_INDEX_BITS   = 32;

  localparam logic [POINT_COUNT_BITS-1:0] POINT_COUNT_RESET = POINT_COUNT_BITS'(1);

  typedef struct packed {
    logic signed [RAW_INDEX_BITS-1:0] vertex_index;
    logic                             face_end;
    logic                             mesh_end;
  } vertex_item_t;

  typedef struct packed {
    logic [INDEX_BITS-1:0] corner_a;
    logic [INDEX_BITS-1:0] corner_b;
    logic [INDEX_BITS-1:0] corner_c;
    logic                  last_of_face;
  } triangle_item_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_LOAD0,
    B_LOAD1,
    B_FETCH
  } back_state_t;

endpackage

// ----- rtl/core/pft_front.sv -----
// ----------------------------------------------------------------------------
// pft_front
// Accepts corner indices, checks them, writes them to the open face buffer
// and queues a fan job when a good face closes.
// ----------------------------------------------------------------------------
module pft_front #(
  parameter int MAX_FACE_CORNERS = 32,
  parameter int CW = $clog2(MAX_FACE_CORNERS + 1),
  parameter int AW = $clog2(MAX_FACE_CORNERS)
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic [pft_pkg::POINT_COUNT_BITS-1:0]   point_count,
  input  logic                                   vertex_valid,
  output logic                                   vertex_stall,
  input  pft_pkg::vertex_item_t                  vertex,
  input  logic                                   q_full,
  input  logic                                   wr_bank,
  output logic                                   wr_en,
  output logic [AW:0]                            wr_addr,
  output logic [pft_pkg::INDEX_BITS-1:0]         wr_data,
  output logic                                   q_push,
  output logic [CW-1:0]                          q_push_count
);
  import pft_pkg::*;

  logic [CW-1:0]             corner_count;
  logic                      face_bad;
  logic                      accept;
  logic [RAW_INDEX_BITS-1:0] raw;
  logic                      index_ok;
  logic                      room;
  logic [CW-1:0]             count_next;
  logic                      bad_next;

  assign vertex_stall = q_full;
  assign accept       = vertex_valid && !vertex_stall;
  assign raw          = vertex.vertex_index;

  // negative, at or above point_count, or too wide for the buffer: bad
  assign index_ok = !raw[RAW_INDEX_BITS-1]
                 && ({1'b0, raw} < (RAW_INDEX_BITS + 1)'(point_count))
                 && ((raw >> INDEX_BITS) == '0);

  assign room       = corner_count < CW'(MAX_FACE_CORNERS);
  assign count_next = room ? corner_count + CW'(1) : corner_count;
  assign bad_next   = face_bad || !index_ok || !room;

  assign wr_en   = accept && room;
  assign wr_addr = {wr_bank, corner_count[AW-1:0]};
  assign wr_data = raw[INDEX_BITS-1:0];

  assign q_push       = accept && vertex.face_end && !bad_next && (count_next >= CW'(3));
  assign q_push_count = count_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      corner_count <= '0;
      face_bad     <= 1'b0;
    end else if (accept) begin
      if (vertex.face_end || vertex.mesh_end) begin
        corner_count <= '0;
        face_bad     <= 1'b0;
      end else begin
        corner_count <= count_next;
        face_bad     <= bad_next;
      end
    end
  end

endmodule

// ----- rtl/core/pft_job_queue.sv -----
// ----------------------------------------------------------------------------
// pft_job_queue
// Two-entry queue of closed faces; entry i owns face buffer bank i.
// ----------------------------------------------------------------------------
module pft_job_queue #(
  parameter int CW = 6
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  logic [CW-1:0] push_count,
  input  logic          pop,
  output logic          full,
  output logic          busy,
  output logic [CW-1:0] head_count,
  output logic          wr_ptr,
  output logic          rd_ptr
);
  import pft_pkg::*;

  logic [CW-1:0] counts [2];
  logic [1:0]    occupancy;

  assign full       = occupancy == 2'd2;
  assign busy       = occupancy != 2'd0;
  assign head_count = counts[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      counts[wr_ptr] <= push_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occupancy <= 2'd0;
      wr_ptr    <= 1'b0;
      rd_ptr    <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, pop})
        2'b10:   occupancy <= occupancy + 2'd1;
        2'b01:   occupancy <= occupancy - 2'd1;
        default: occupancy <= occupancy;
      endcase
    end
  end

endmodule

// ----- rtl/core/pft_back.sv -----
// ----------------------------------------------------------------------------
// pft_back
// Holds the two face buffer banks and walks the head face, emitting one
// fan triangle per cycle while the output is not stalled into the output register.
// ----------------------------------------------------------------------------
module pft_back #(
  parameter int MAX_FACE_CORNERS = 32,
  parameter int CW = $clog2(MAX_FACE_CORNERS + 1),
  parameter int AW = $clog2(MAX_FACE_CORNERS)
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           wr_en,
  input  logic [AW:0]                    wr_addr,
  input  logic [pft_pkg::INDEX_BITS-1:0] wr_data,
  input  logic                           q_busy,
  input  logic [CW-1:0]                  head_count,
  input  logic                           rd_bank,
  output logic                           q_pop,
  output logic                           triangle_valid,
  input  logic                           triangle_stall,
  output pft_pkg::triangle_item_t        triangle
);
  import pft_pkg::*;

  logic [INDEX_BITS-1:0] mem [2**(AW+1)];
  logic [INDEX_BITS-1:0] rd_data;
  logic [AW:0]           rd_addr;
  logic [CW-1:0]         rd_idx;

  back_state_t           state;
  back_state_t           state_next;
  logic [CW-1:0]         k;
  logic [INDEX_BITS-1:0] v0;
  logic [INDEX_BITS-1:0] prev;
  logic                  out_free;
  logic                  last;
  logic                  fire;

  assign out_free = !triangle_valid || !triangle_stall;
  assign last     = k == (head_count - CW'(1));

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  always_comb begin
    state_next = state;
    case (state)
      B_IDLE:  if (q_busy) state_next = B_LOAD0;
      B_LOAD0: state_next = B_LOAD1;
      B_LOAD1: state_next = B_FETCH;
      B_FETCH: if (out_free && last) state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  // one buffer read per cycle; hold the address while the output is stalled
  always_comb begin
    fire   = 1'b0;
    rd_idx = '0;
    case (state)
      B_IDLE:  rd_idx = '0;
      B_LOAD0: rd_idx = CW'(1);
      B_LOAD1: rd_idx = k;
      B_FETCH: begin
        fire   = out_free;
        rd_idx = out_free ? k + CW'(1) : k;
      end
      default: rd_idx = '0;
    endcase
  end

  assign rd_addr = {rd_bank, rd_idx[AW-1:0]};
  assign q_pop   = fire && last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      k     <= '0;
    end else begin
      state <= state_next;
      if (state == B_LOAD0) begin
        k <= CW'(2);
      end else if (fire) begin
        k <= k + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == B_LOAD0) begin
      v0 <= rd_data;
    end
    if (state == B_LOAD1 || fire) begin
      prev <= rd_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      triangle_valid <= 1'b0;
    end else if (fire) begin
      triangle_valid <= 1'b1;
    end else if (!triangle_stall) begin
      triangle_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      triangle.corner_a     <= v0;
      triangle.corner_b     <= prev;
      triangle.corner_c     <= rd_data;
      triangle.last_of_face <= last;
    end
  end

endmodule

// ----- rtl/core/polygon_fan_triangulator_core.sv -----
// B_LOAD0 and B_LOAD1 start each face's walk, set by the single read port of the face buffer.
// One corner per cycle in while the queue is not full; one triangle per cycle out while the
//   output is not stalled.
// Two face buffer banks: the front stalls only while both hold queued faces not yet fully emitted.
// Reset (rst, synchronous): empties the queue, clears the open face, point_count back to 1.
// ----------------------------------------------------------------------------
// polygon_fan_triangulator_core
// Buffers polygon faces and emits each good face as a triangle fan.
// ----------------------------------------------------------------------------
module polygon_fan_triangulator_core #(
  parameter int MAX_FACE_CORNERS = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 vertex_valid,
  output logic                                 vertex_stall,
  input  pft_pkg::vertex_item_t                vertex,
  output logic                                 triangle_valid,
  input  logic                                 triangle_stall,
  output pft_pkg::triangle_item_t              triangle,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [pft_pkg::POINT_COUNT_BITS-1:0] cfg_point_count
);
  import pft_pkg::*;

  localparam int CW = $clog2(MAX_FACE_CORNERS + 1);
  localparam int AW = $clog2(MAX_FACE_CORNERS);

  logic [POINT_COUNT_BITS-1:0] point_count;
  logic                        wr_en;
  logic [AW:0]                 wr_addr;
  logic [INDEX_BITS-1:0]       wr_data;
  logic                        q_push;
  logic [CW-1:0]               q_push_count;
  logic                        q_pop;
  logic                        q_full;
  logic                        q_busy;
  logic [CW-1:0]               head_count;
  logic                        wr_bank;
  logic                        rd_bank;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      point_count <= POINT_COUNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      point_count <= cfg_point_count;
    end
  end

  pft_front #(
    .MAX_FACE_CORNERS(MAX_FACE_CORNERS),
    .CW(CW),
    .AW(AW)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .point_count  (point_count),
    .vertex_valid (vertex_valid),
    .vertex_stall (vertex_stall),
    .vertex       (vertex),
    .q_full       (q_full),
    .wr_bank      (wr_bank),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data),
    .q_push       (q_push),
    .q_push_count (q_push_count)
  );

  pft_job_queue #(
    .CW(CW)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_count (q_push_count),
    .pop        (q_pop),
    .full       (q_full),
    .busy       (q_busy),
    .head_count (head_count),
    .wr_ptr     (wr_bank),
    .rd_ptr     (rd_bank)
  );

  pft_back #(
    .MAX_FACE_CORNERS(MAX_FACE_CORNERS),
    .CW(CW),
    .AW(AW)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .wr_en          (wr_en),
    .wr_addr        (wr_addr),
    .wr_data        (wr_data),
    .q_busy         (q_busy),
    .head_count     (head_count),
    .rd_bank        (rd_bank),
    .q_pop          (q_pop),
    .triangle_valid (triangle_valid),
    .triangle_stall (triangle_stall),
    .triangle       (triangle)
  );

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full) else $error("face queued while both banks are held");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_busy) else $error("face retired from an empty queue");

  a_bank_separation: assert property (@(posedge clk) disable iff (rst)
    (wr_en && q_busy) |-> (wr_addr[AW] != rd_bank))
    else $error("open face written into the bank being emitted");

  a_pop_marks_last: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> (triangle_valid && triangle.last_of_face))
    else $error("face retired without its last triangle beat");

endmodule
